// ===== sv/tcfe_pkg.sv =====
// Shared types and constants for the one-minute radio time code frame encoder.
// No dependencies; used by tcfe_frame and time_code_frame_encoder.
package tcfe_pkg;

  // Frame geometry.
  localparam int unsigned FRAME_LEN = 60;
  localparam int unsigned SEC_W     = 6;
  localparam logic [SEC_W-1:0] SEC_FIRST = 6'd0;
  localparam logic [SEC_W-1:0] SEC_LAST  = 6'd59;

  // Symbol codes on the output.
  localparam logic [1:0] SYM_ZERO = 2'd0;
  localparam logic [1:0] SYM_ONE  = 2'd1;
  localparam logic [1:0] SYM_MARK = 2'd2;

  // Upper limits of the request fields; larger values are clamped.
  localparam logic [5:0]  MINUTE_MAX = 6'd59;
  localparam logic [4:0]  HOUR_MAX   = 5'd23;
  localparam logic [8:0]  DAY_MAX    = 9'd366;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;

  // Request after clamping, with the year split into year / 100 and the
  // low seven bits of the year (enough to rebuild year % 100).
  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [8:0] day;
    logic [6:0] year_hi;
    logic [6:0] year_lo;
    logic       leap_sec;
    logic       dst;
  } tcfe_req_t;

  // Seconds that always carry a marker.
  function automatic logic [FRAME_LEN-1:0] build_markers();
    logic [FRAME_LEN-1:0] m;
    m = '0;
    m[0]  = 1'b1;
    m[9]  = 1'b1;
    m[19] = 1'b1;
    m[29] = 1'b1;
    m[39] = 1'b1;
    m[49] = 1'b1;
    m[59] = 1'b1;
    return m;
  endfunction

  localparam logic [FRAME_LEN-1:0] FRAME_MARKERS = build_markers();

endpackage

// ===== sv/time_code_frame_encoder.sv =====
// One-minute radio time code frame encoder, top level.
// Depends on tcfe_pkg and tcfe_frame.
//
// Usage: a request word on the s_ channel carries minute, hour, day of year,
// full year, the leap-second flag and the DST flag. For each request the
// block sends 60 words on the m_ channel, second 0 first, each holding the
// symbol (zero, one or marker) and its second index; m_tlast marks second 59.
// Out-of-range fields are clamped to their maximum before encoding.
//
// A taken request moves through the input register into the frame register;
// then its first symbol is valid. Throughput: one symbol per cycle while the
// receiver accepts, set by the output counter over the frame. One request waits
// in the input register while a frame is sent, so frames follow with no gap.
//
// Reset clears the input register and the frame in flight; no words are
// sent until a new request arrives. When the receiver stalls, the current
// symbol holds and the input side fills and then drops s_tready.
module time_code_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // minute_value[5:0], hour_value[10:6], day_of_year[19:11], full_year[33:20],
  // leap_second_pending[34], dst_active[35], zero fill [39:36]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // symbol_code[1:0], second_index[7:2]
  output logic [7:0]  m_tdata,
  output logic        m_tlast
);

  localparam logic [12:0] YEAR_RECIP = 13'd5243;
  localparam int unsigned YEAR_SHIFT = 19;

  logic [5:0]  in_minute;
  logic [4:0]  in_hour;
  logic [8:0]  in_day;
  logic [13:0] in_year;
  logic [13:0] year_clamp;
  logic [25:0] year_prod;
  tcfe_pkg::tcfe_req_t req_in;

  tcfe_pkg::tcfe_req_t pend;
  logic                pend_valid;
  logic [tcfe_pkg::FRAME_LEN-1:0] frame_ones;
  logic [tcfe_pkg::FRAME_LEN-1:0] act_ones;
  logic                act_valid;
  logic [tcfe_pkg::SEC_W-1:0] sec;

  logic s_fire;
  logic m_fire;
  logic frame_done;
  logic load_act;

  // Clamp the request fields and take year / 100 by a reciprocal multiply.
  assign in_minute  = s_tdata[5:0];
  assign in_hour    = s_tdata[10:6];
  assign in_day     = s_tdata[19:11];
  assign in_year    = s_tdata[33:20];
  assign year_clamp = (in_year > tcfe_pkg::YEAR_MAX) ? tcfe_pkg::YEAR_MAX : in_year;
  assign year_prod  = 26'(year_clamp) * 26'(YEAR_RECIP);

  always_comb begin
    req_in.minute   = (in_minute > tcfe_pkg::MINUTE_MAX) ? tcfe_pkg::MINUTE_MAX : in_minute;
    req_in.hour     = (in_hour > tcfe_pkg::HOUR_MAX) ? tcfe_pkg::HOUR_MAX : in_hour;
    req_in.day      = (in_day > tcfe_pkg::DAY_MAX) ? tcfe_pkg::DAY_MAX : in_day;
    req_in.year_hi  = year_prod[YEAR_SHIFT+6:YEAR_SHIFT];
    req_in.year_lo  = year_clamp[6:0];
    req_in.leap_sec = s_tdata[34];
    req_in.dst      = s_tdata[35];
  end

  // Handshake control between the input register and the frame in flight.
  assign s_fire     = s_tvalid && s_tready;
  assign m_fire     = m_tvalid && m_tready;
  assign frame_done = m_fire && (sec == tcfe_pkg::SEC_LAST);
  assign load_act   = pend_valid && (!act_valid || frame_done);
  assign s_tready   = !pend_valid || load_act;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s_fire) begin
      pend_valid <= 1'b1;
    end else if (load_act) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      pend <= req_in;
    end
  end

  tcfe_frame u_frame (
    .req  (pend),
    .ones (frame_ones)
  );

  // Frame register and second counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      sec       <= tcfe_pkg::SEC_FIRST;
    end else if (load_act) begin
      act_valid <= 1'b1;
      sec       <= tcfe_pkg::SEC_FIRST;
    end else if (frame_done) begin
      act_valid <= 1'b0;
      sec       <= tcfe_pkg::SEC_FIRST;
    end else if (m_fire) begin
      sec       <= sec + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_act) begin
      act_ones <= frame_ones;
    end
  end

  // Output word: markers override the data bits at their fixed seconds.
  assign m_tvalid     = act_valid;
  assign m_tdata[7:2] = sec;
  assign m_tdata[1:0] = tcfe_pkg::FRAME_MARKERS[sec] ? tcfe_pkg::SYM_MARK :
                        (act_ones[sec] ? tcfe_pkg::SYM_ONE : tcfe_pkg::SYM_ZERO);
  assign m_tlast      = (sec == tcfe_pkg::SEC_LAST);

  // The counter never leaves the frame.
  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    act_valid |-> (sec <= tcfe_pkg::SEC_LAST))
    else $error("second counter beyond end of frame");

  // While a request waits, a frame is in flight in the next cycle.
  a_pend_moves: assert property (@(posedge clk) disable iff (rst)
    pend_valid |=> act_valid)
    else $error("pending request not started");

  // Each accepted symbol advances the second by one within a frame.
  a_sec_step: assert property (@(posedge clk) disable iff (rst)
    (m_fire && (sec != tcfe_pkg::SEC_LAST)) |=> (sec == $past(sec) + 6'd1))
    else $error("second index skipped or repeated");

  // With nothing waiting, the end of a frame leaves the output idle.
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (frame_done && !pend_valid) |=> !m_tvalid)
    else $error("output still valid after last symbol");

endmodule

// ===== sv/tcfe_frame.sv =====
// Builds the data bits of one frame from a clamped request (BCD fields,
// leap-year, leap-second and DST bits). Depends on tcfe_pkg.
module tcfe_frame (
  input  tcfe_pkg::tcfe_req_t               req,
  output logic [tcfe_pkg::FRAME_LEN-1:0]    ones
);

  typedef logic [7:0] bcd_lut_t [100];

  // Two-digit BCD of 0..99, built at elaboration.
  function automatic bcd_lut_t build_bcd_lut();
    bcd_lut_t lut;
    for (int i = 0; i < 100; i++) begin
      lut[i] = {4'(i / 10), 4'(i % 10)};
    end
    return lut;
  endfunction

  localparam bcd_lut_t BCD_LUT = build_bcd_lut();

  logic [1:0] day_hund;
  logic [6:0] day_rem;
  logic [6:0] year_rem;
  logic       leap_year;
  logic [7:0] min_bcd;
  logic [7:0] hour_bcd;
  logic [7:0] day_bcd;
  logic [7:0] year_bcd;

  // Split the day into its hundreds digit and the remainder below 100.
  always_comb begin
    priority if (req.day >= 9'd300) begin
      day_hund = 2'd3;
      day_rem  = 7'(req.day - 9'd300);
    end else if (req.day >= 9'd200) begin
      day_hund = 2'd2;
      day_rem  = 7'(req.day - 9'd200);
    end else if (req.day >= 9'd100) begin
      day_hund = 2'd1;
      day_rem  = 7'(req.day - 9'd100);
    end else begin
      day_hund = 2'd0;
      day_rem  = 7'(req.day);
    end
  end

  // Year modulo 100 is below 128, so seven bits of the difference suffice.
  assign year_rem  = req.year_lo - 7'(req.year_hi * 7'd100);
  assign leap_year = (req.year_lo[1:0] == 2'd0) &&
                     ((year_rem != 7'd0) || (req.year_hi[1:0] == 2'd0));

  assign min_bcd  = BCD_LUT[{1'b0, req.minute}];
  assign hour_bcd = BCD_LUT[{2'b00, req.hour}];
  assign day_bcd  = BCD_LUT[day_rem];
  assign year_bcd = BCD_LUT[year_rem];

  // Place each field most significant bit first at its fixed seconds.
  always_comb begin
    ones = '0;
    ones[1]  = min_bcd[6];
    ones[2]  = min_bcd[5];
    ones[3]  = min_bcd[4];
    ones[5]  = min_bcd[3];
    ones[6]  = min_bcd[2];
    ones[7]  = min_bcd[1];
    ones[8]  = min_bcd[0];
    ones[12] = hour_bcd[5];
    ones[13] = hour_bcd[4];
    ones[15] = hour_bcd[3];
    ones[16] = hour_bcd[2];
    ones[17] = hour_bcd[1];
    ones[18] = hour_bcd[0];
    ones[22] = day_hund[1];
    ones[23] = day_hund[0];
    ones[25] = day_bcd[7];
    ones[26] = day_bcd[6];
    ones[27] = day_bcd[5];
    ones[28] = day_bcd[4];
    ones[30] = day_bcd[3];
    ones[31] = day_bcd[2];
    ones[32] = day_bcd[1];
    ones[33] = day_bcd[0];
    ones[45] = year_bcd[7];
    ones[46] = year_bcd[6];
    ones[47] = year_bcd[5];
    ones[48] = year_bcd[4];
    ones[50] = year_bcd[3];
    ones[51] = year_bcd[2];
    ones[52] = year_bcd[1];
    ones[53] = year_bcd[0];
    ones[55] = leap_year;
    ones[56] = req.leap_sec;
    ones[57] = req.dst;
    ones[58] = req.dst;
  end

endmodule

// ===== dv/time_code_frame_encoder_tb.sv =====
// Self-checking testbench for time_code_frame_encoder: sends time requests and checks
// every symbol word of each 60-second frame against a frame builder kept in the bench.
// Depends on tcfe_pkg and the time_code_frame_encoder RTL.
module time_code_frame_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 5000;

  typedef struct {
    logic [39:0] word;
    bit          wait_drain;
  } time_request_t;

  typedef struct {
    logic [1:0] sym;
    logic [5:0] sec;
    logic       last;
  } frame_symbol_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  time_request_t requests_to_send[$];
  frame_symbol_t symbols_due[$];
  int unsigned   errors = 0;
  logic          frames_drained = 1'b1;
  int unsigned   quiet_cycles = 0;
  int unsigned   burst_left = 1;
  int unsigned   gap_left = 0;
  int unsigned   stall_mode = 0;
  int unsigned   stall_cycle = 0;

  time_code_frame_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Place one BCD digit msb first on consecutive seconds.
  function automatic logic [59:0] bcd_at(input int unsigned digit, input int unsigned nbits,
                                         input int unsigned first);
    logic [59:0] v;
    int unsigned i;
    v = '0;
    for (i = 0; i < nbits; i++) v[first + i] = digit[nbits - 1 - i];
    return v;
  endfunction

  // Build the frame for one request word and queue its 60 symbols.
  function automatic void encode_frame(input logic [39:0] w);
    int unsigned   mi, hr, dy, yr, yy, sec;
    logic [59:0]   ones;
    logic          leap_year;
    frame_symbol_t slot;
    mi = w[5:0];
    hr = w[10:6];
    dy = w[19:11];
    yr = w[33:20];
    if (mi > tcfe_pkg::MINUTE_MAX) mi = tcfe_pkg::MINUTE_MAX;
    if (hr > tcfe_pkg::HOUR_MAX) hr = tcfe_pkg::HOUR_MAX;
    if (dy > tcfe_pkg::DAY_MAX) dy = tcfe_pkg::DAY_MAX;
    if (yr > tcfe_pkg::YEAR_MAX) yr = tcfe_pkg::YEAR_MAX;
    yy = yr % 100;
    leap_year = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    ones = bcd_at(mi / 10, 3, 1) | bcd_at(mi % 10, 4, 5)
         | bcd_at(hr / 10, 2, 12) | bcd_at(hr % 10, 4, 15)
         | bcd_at(dy / 100, 2, 22) | bcd_at((dy / 10) % 10, 4, 25) | bcd_at(dy % 10, 4, 30)
         | bcd_at(yy / 10, 4, 45) | bcd_at(yy % 10, 4, 50);
    ones[55] = leap_year;
    ones[56] = w[34];
    ones[57] = w[35];
    ones[58] = w[35];
    for (sec = 0; sec < tcfe_pkg::FRAME_LEN; sec++) begin
      // Markers sit on second 0 and on every second ending in nine.
      if (sec == 0 || sec % 10 == 9) slot.sym = tcfe_pkg::SYM_MARK;
      else slot.sym = ones[sec] ? tcfe_pkg::SYM_ONE : tcfe_pkg::SYM_ZERO;
      slot.sec  = sec[5:0];
      slot.last = (sec[5:0] == tcfe_pkg::SEC_LAST);
      symbols_due.push_back(slot);
    end
  endfunction

  function automatic void queue_request(input int unsigned mi, input int unsigned hr,
                                        input int unsigned dy, input int unsigned yr,
                                        input bit ls, input bit dst, input bit wait_drain);
    time_request_t r;
    r.word = {4'b0, dst, ls, yr[13:0], dy[8:0], hr[4:0], mi[5:0]};
    r.wait_drain = wait_drain;
    requests_to_send.push_back(r);
  endfunction

  // Sender: bursts of request words with random gaps; a flagged request waits
  // until every symbol of the earlier frames has been received.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (requests_to_send.size() == 0 ||
                   (requests_to_send[0].wait_drain && (s_tvalid || !frames_drained))) begin
        s_tvalid <= 1'b0;
      end else begin
        s_tdata  <= requests_to_send[0].word;
        s_tvalid <= 1'b1;
        requests_to_send.pop_front();
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 6);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        end
      end
    end
  end

  // Receiver: m_tready follows one of four stall styles, chosen anew at random.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      stall_cycle++;
      if (stall_cycle % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 99) >= 25);
        2: m_tready <= ($urandom_range(0, 99) >= 70);
        default: m_tready <= (stall_cycle % 7 >= 3);
      endcase
    end
  end

  // Monitor: check each symbol word first, then predict the frame of a taken request.
  always @(posedge clk) begin
    frame_symbol_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (symbols_due.size() == 0) begin
          $display("%0t: unexpected word: got sym=%0d sec=%0d last=%0d",
                   $time, m_tdata[1:0], m_tdata[7:2], m_tlast);
          errors++;
        end else begin
          want = symbols_due.pop_front();
          if (m_tdata[1:0] !== want.sym) begin
            $display("%0t: symbol_code mismatch at sec %0d: expected %0d, got %0d",
                     $time, want.sec, want.sym, m_tdata[1:0]);
            errors++;
          end
          if (m_tdata[7:2] !== want.sec) begin
            $display("%0t: second_index mismatch: expected %0d, got %0d",
                     $time, want.sec, m_tdata[7:2]);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: frame_last mismatch at sec %0d: expected %0d, got %0d",
                     $time, want.sec, want.last, m_tlast);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) encode_frame(s_tdata);
      frames_drained <= (symbols_due.size() == 0);
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned k, mi, hr, dy, yr;

    // Directed requests: field extremes, clamping, day zero and leap-year rules.
    queue_request(0, 0, 1, 2000, 0, 0, 0);
    queue_request(59, 23, 366, 9999, 1, 1, 0);
    queue_request(63, 31, 511, 16383, 1, 0, 0);
    queue_request(60, 24, 367, 10000, 0, 1, 0);
    queue_request(0, 0, 0, 0, 0, 0, 1);
    queue_request(9, 9, 99, 1900, 1, 1, 0);
    queue_request(10, 10, 100, 2024, 0, 0, 0);
    queue_request(19, 19, 199, 2023, 1, 0, 0);
    queue_request(20, 20, 200, 2100, 0, 1, 0);
    queue_request(29, 21, 299, 2400, 1, 1, 0);
    queue_request(30, 22, 300, 100, 0, 0, 0);
    queue_request(45, 12, 365, 400, 1, 0, 0);
    queue_request(58, 1, 250, 1999, 0, 1, 0);
    queue_request(42, 15, 123, 16000, 1, 1, 0);
    queue_request(37, 27, 400, 8765, 0, 0, 0);
    queue_request(61, 7, 77, 2096, 1, 0, 0);

    // Random requests, mostly in range with some full-width values.
    for (k = 0; k < 104; k++) begin
      mi = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
      hr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
      dy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 366);
      case ($urandom_range(0, 7))
        0: yr = $urandom_range(0, 16383);
        1: yr = 100 * $urandom_range(0, 99);
        default: yr = $urandom_range(0, 9999);
      endcase
      queue_request(mi, hr, dy, yr, $urandom_range(0, 1), $urandom_range(0, 1), k % 40 == 39);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Let all requests go out, then all frames come back.
    @(negedge clk);
    while (requests_to_send.size() != 0 || s_tvalid) @(negedge clk);
    while (!frames_drained) @(negedge clk);
    repeat (20) @(negedge clk);
    if (symbols_due.size() != 0) begin
      $display("%0t: %0d symbols expected but never received, next sec=%0d sym=%0d",
               $time, symbols_due.size(), symbols_due[0].sec, symbols_due[0].sym);
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tcfe_pkg.sv
sv/tcfe_frame.sv
sv/time_code_frame_encoder.sv
dv/time_code_frame_encoder_tb.sv
